// ===== hdl/fac_pkg.sv =====
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants for follow_accel_command
// Field widths, register indexes, fixed-point constants and the stage
// records passed between the pipeline modules.
// ----------------------------------------------------------------------------
package fac_pkg;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_RUN_MODE   = 3'd0;
   localparam logic [2:0] REG_SPEED_KMH  = 3'd1;
   localparam logic [2:0] REG_GAP_M      = 3'd2;
   localparam logic [2:0] REG_GAIN_ACCEL = 3'd3;
   localparam logic [2:0] REG_GAIN_SPEED = 3'd4;
   localparam logic [2:0] REG_GAIN_GAP   = 3'd5;
   localparam logic [2:0] REG_ACC_UPPER  = 3'd6;
   localparam logic [2:0] REG_ACC_LOWER  = 3'd7;

   // Reset values of the registers
   localparam logic              RST_RUN_MODE  = 1'b1;
   localparam logic [7:0]        RST_SPEED_KMH = 8'd0;
   localparam logic [7:0]        RST_GAP_M     = 8'd10;
   localparam logic signed [8:0] RST_ACC_UPPER = 9'sd20;
   localparam logic signed [8:0] RST_ACC_LOWER = -9'sd50;

   // Width of the scaled command Y = acc * 1228800
   localparam int Y_W = 40;

   // Fixed-point constants (Y units)
   localparam int ACCEL_BIAS  = 150;       // raw accel code of 0 m/s^2
   localparam int BAND_HI     = 1000;      // gap error band, cm (exclusive)
   localparam int BAND_LO     = -500;
   localparam int BRAKE_PCT   = 45;        // hard brake threshold
   localparam int BRAKE_STEP  = 3072000;   // 2.5 m/s^2 in Y units
   localparam int Y_PER_TENTH = 122880;    // 0.1 m/s^2 in Y units = 15 << 13
   localparam int CODE_OFFSET = 18432000;  // 15 m/s^2 in Y units
   localparam int TENTH_SHIFT = 13;
   localparam int RECIP_15    = 8739;      // ceil(2^17 / 15)
   localparam int RECIP_SHIFT = 17;
   localparam int CODE_MAX    = 300;

   // Configuration register file
   typedef struct packed {
      logic              run_mode;
      logic [7:0]        desired_speed_kmh;
      logic [7:0]        desired_gap_m;
      logic signed [15:0] gain_accel;
      logic signed [15:0] gain_speed;
      logic signed [15:0] gain_gap;
      logic signed [8:0] accel_upper;
      logic signed [8:0] accel_lower;
   } cfg_type;

   // One input sample
   typedef struct packed {
      logic [11:0] lead_speed_raw;
      logic [11:0] own_speed_raw;
      logic [8:0]  lead_accel_raw;
      logic [15:0] range_cm;
      logic [7:0]  lead_brake_pct;
   } sample_type;

   // Products and flags after the multiply stage
   typedef struct packed {
      logic signed [26:0] term_accel;
      logic signed [28:0] term_speed;
      logic signed [33:0] term_gap;
      logic signed [17:0] speed_err;
      logic               in_band;
      logic               hard_brake;
      logic               run_mode;
   } prod_type;

   // Clamped command ready for coding
   typedef struct packed {
      logic        positive;
      logic [12:0] eighths;   // offset command >> 13
      logic        limited;
   } clamp_type;

endpackage

// ===== hdl/fac_gain_mult.sv =====
// ----------------------------------------------------------------------------
// fac_gain_mult: gain multiply stage
// Forms the leader accel, speed difference and gap error, multiplies each by
// its gain and registers the products with the band and brake flags.
// ----------------------------------------------------------------------------
module fac_gain_mult (
   input  logic                clock,
   input  logic                enable,
   input  fac_pkg::sample_type smp,
   input  fac_pkg::cfg_type    cfg,
   output fac_pkg::prod_type   prod_ff
);

   logic signed [10:0] acc_dev;
   logic signed [12:0] spd_diff;
   logic signed [17:0] gap_err;
   logic signed [15:0] k_accel;
   logic signed [15:0] k_speed;
   logic signed [15:0] k_gap;
   fac_pkg::prod_type  prod_in;

   // Build differences and products
   always_comb begin
      k_accel  = cfg.gain_accel;
      k_speed  = cfg.gain_speed;
      k_gap    = cfg.gain_gap;
      acc_dev  = 11'({2'b00, smp.lead_accel_raw}) - 11'(fac_pkg::ACCEL_BIAS);
      spd_diff = {1'b0, smp.lead_speed_raw} - {1'b0, smp.own_speed_raw};
      gap_err  = 18'({2'b00, smp.range_cm}) - 18'(cfg.desired_gap_m) * 18'd100;

      prod_in.term_accel = k_accel * acc_dev;
      prod_in.term_speed = k_speed * spd_diff;
      prod_in.term_gap   = k_gap * gap_err;
      prod_in.speed_err  = 18'(cfg.desired_speed_kmh) * 18'd50
                           - 18'(smp.own_speed_raw) * 18'd18;
      prod_in.in_band    = (gap_err < 18'(fac_pkg::BAND_HI))
                           && (gap_err > 18'(fac_pkg::BAND_LO));
      prod_in.hard_brake = smp.lead_brake_pct > 8'(fac_pkg::BRAKE_PCT);
      prod_in.run_mode   = cfg.run_mode;
   end

   // Hold while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== hdl/fac_combine.sv =====
// ----------------------------------------------------------------------------
// fac_combine: command combine stage
// Weights the products by gap band, quadruples a negative command, applies
// the hard-brake step and selects the speed-keeping command by mode.
// ----------------------------------------------------------------------------
module fac_combine (
   input  logic                               clock,
   input  logic                               enable,
   input  fac_pkg::prod_type                  prod,
   output logic signed [fac_pkg::Y_W-1:0]     y_ff
);

   logic signed [fac_pkg::Y_W-1:0] sum_av;
   logic signed [fac_pkg::Y_W-1:0] gap_y;
   logic signed [fac_pkg::Y_W-1:0] y_lin;
   logic signed [fac_pkg::Y_W-1:0] y_neg;
   logic signed [fac_pkg::Y_W-1:0] y_dist;
   logic signed [fac_pkg::Y_W-1:0] y_speed;
   logic signed [fac_pkg::Y_W-1:0] y_in;

   // Gap-keeping law and speed-keeping command
   always_comb begin
      sum_av = fac_pkg::Y_W'(prod.term_accel) + fac_pkg::Y_W'(prod.term_speed);
      gap_y  = fac_pkg::Y_W'(prod.term_gap);
      if (prod.in_band) begin
         y_lin = sum_av * fac_pkg::Y_W'(30) + gap_y * fac_pkg::Y_W'(3);
      end else begin
         y_lin = sum_av * fac_pkg::Y_W'(15) + gap_y * fac_pkg::Y_W'(6);
      end
      y_neg  = (y_lin < 0) ? (y_lin <<< 2) : y_lin;
      y_dist = prod.hard_brake ? (y_neg - fac_pkg::Y_W'(fac_pkg::BRAKE_STEP)) : y_neg;
      y_speed = fac_pkg::Y_W'(prod.speed_err) <<< 12;
      y_in   = prod.run_mode ? y_dist : y_speed;
   end

   // Hold while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         y_ff <= y_in;
      end
   end

endmodule

// ===== hdl/fac_limit_code.sv =====
// ----------------------------------------------------------------------------
// fac_limit_code: clamp and coding stages
// Clamps the command to the configured limits, offsets it by 15 m/s^2 and
// divides by 0.1 m/s^2 (shift by 13, then multiply by a reciprocal of 15).
// ----------------------------------------------------------------------------
module fac_limit_code (
   input  logic                           clock,
   input  logic                           enable,
   input  logic signed [fac_pkg::Y_W-1:0] y,
   input  logic signed [8:0]              accel_upper,
   input  logic signed [8:0]              accel_lower,
   output logic [8:0]                     code_ff,
   output logic                           limited_ff
);

   logic signed [fac_pkg::Y_W-1:0] y_upper;
   logic signed [fac_pkg::Y_W-1:0] y_lower;
   logic signed [fac_pkg::Y_W-1:0] y_clamp;
   logic signed [fac_pkg::Y_W-1:0] num;
   fac_pkg::clamp_type             clamp_in;
   fac_pkg::clamp_type             clamp_ff;
   logic [26:0]                    recip_prod;
   logic [9:0]                     quot;
   logic [8:0]                     code_in;

   // Clamp, upper limit tested first
   always_comb begin
      y_upper = fac_pkg::Y_W'(accel_upper) * fac_pkg::Y_W'(fac_pkg::Y_PER_TENTH);
      y_lower = fac_pkg::Y_W'(accel_lower) * fac_pkg::Y_W'(fac_pkg::Y_PER_TENTH);
      clamp_in.limited = 1'b1;
      if (y > y_upper) begin
         y_clamp = y_upper;
      end else if (y < y_lower) begin
         y_clamp = y_lower;
      end else begin
         y_clamp = y;
         clamp_in.limited = 1'b0;
      end
      num = y_clamp + fac_pkg::Y_W'(fac_pkg::CODE_OFFSET);
      clamp_in.positive = num > 0;
      clamp_in.eighths  = num[fac_pkg::TENTH_SHIFT +: 13];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         clamp_ff <= clamp_in;
      end
   end

   // Divide by 15 and saturate the code
   always_comb begin
      recip_prod = 27'(clamp_ff.eighths) * 27'(fac_pkg::RECIP_15);
      quot       = recip_prod[fac_pkg::RECIP_SHIFT +: 10];
      if (!clamp_ff.positive) begin
         code_in = 9'd0;
      end else if (quot > 10'(fac_pkg::CODE_MAX)) begin
         code_in = 9'(fac_pkg::CODE_MAX);
      end else begin
         code_in = quot[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         code_ff    <= code_in;
         limited_ff <= clamp_ff.limited;
      end
   end

endmodule

// ===== hdl/follow_accel_command.sv =====
// ----------------------------------------------------------------------------
// follow_accel_command: longitudinal acceleration command for a follower
// Computes a coded acceleration command from leader/follower sensor data.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one sensor sample per transaction (speeds, leader accel,
//          range, leader brake pedal), packed in req_tdata.
//   rsp_*  returns one transaction per sample: accel_code in rsp_tdata and
//          the clamp flag in rsp_tuser, in sample order.
//   csr_*  writes one register per transaction (index, data); it is always
//          ready. Write only while no sample is in flight.
// Pipeline: a sample passes from the input register, loaded at the accepting
//   edge, through the gain multiply, combine, clamp and divide-by-15 coding
//   registers to rsp_*.
// Throughput: one sample per cycle while the result channel is not stalled;
//   the five-stage register pipeline holds up to five samples at once.
// Stall: when rsp_tready is low with a result waiting, the whole pipeline
//   holds and req_tready drops in the same cycle; no result is lost.
// Reset: clears all pipeline valid bits and loads the register defaults
//   (distance mode, gap 10 m, limits +2.0 / -5.0 m/s^2, gains zero).
// ----------------------------------------------------------------------------
module follow_accel_command (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // lead_speed_raw[11:0], own_speed_raw[23:12], lead_accel_raw[32:24],
   // range_cm[48:33], lead_brake_pct[56:49], zero fill [63:57]
   input  logic [63:0] req_tdata,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accel_code[8:0], zero fill [15:9]
   output logic [15:0] rsp_tdata,
   // limited[0]
   output logic        rsp_tuser,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   fac_pkg::cfg_type                cfg_ff;
   fac_pkg::sample_type             smp_ff;
   fac_pkg::sample_type             smp_in;
   fac_pkg::prod_type               prod;
   logic signed [fac_pkg::Y_W-1:0]  y_cmd;
   logic [8:0]                      code;
   logic                            limited;
   logic [4:0]                      valid_ff;
   logic [4:0]                      valid_in;
   logic                            enable;

   // Advance the pipeline unless a result is held back
   assign enable     = !valid_ff[4] || rsp_tready;
   assign req_tready = enable;
   assign csr_ready  = 1'b1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_mode          <= fac_pkg::RST_RUN_MODE;
         cfg_ff.desired_speed_kmh <= fac_pkg::RST_SPEED_KMH;
         cfg_ff.desired_gap_m     <= fac_pkg::RST_GAP_M;
         cfg_ff.gain_accel        <= '0;
         cfg_ff.gain_speed        <= '0;
         cfg_ff.gain_gap          <= '0;
         cfg_ff.accel_upper       <= fac_pkg::RST_ACC_UPPER;
         cfg_ff.accel_lower       <= fac_pkg::RST_ACC_LOWER;
      end else if (csr_valid) begin
         case (csr_index)
            fac_pkg::REG_RUN_MODE:   cfg_ff.run_mode          <= csr_wdata[0];
            fac_pkg::REG_SPEED_KMH:  cfg_ff.desired_speed_kmh <= csr_wdata[7:0];
            fac_pkg::REG_GAP_M:      cfg_ff.desired_gap_m     <= csr_wdata[7:0];
            fac_pkg::REG_GAIN_ACCEL: cfg_ff.gain_accel        <= csr_wdata;
            fac_pkg::REG_GAIN_SPEED: cfg_ff.gain_speed        <= csr_wdata;
            fac_pkg::REG_GAIN_GAP:   cfg_ff.gain_gap          <= csr_wdata;
            fac_pkg::REG_ACC_UPPER:  cfg_ff.accel_upper       <= csr_wdata[8:0];
            fac_pkg::REG_ACC_LOWER:  cfg_ff.accel_lower       <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack the sample transaction
   always_comb begin
      smp_in.lead_speed_raw = req_tdata[11:0];
      smp_in.own_speed_raw  = req_tdata[23:12];
      smp_in.lead_accel_raw = req_tdata[32:24];
      smp_in.range_cm       = req_tdata[48:33];
      smp_in.lead_brake_pct = req_tdata[56:49];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (enable) begin
         smp_ff <= smp_in;
      end
   end

   // Shift the valid bits along with the data
   assign valid_in = {valid_ff[3:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   fac_gain_mult u_mult (
      .clock   (clock),
      .enable  (enable),
      .smp     (smp_ff),
      .cfg     (cfg_ff),
      .prod_ff (prod)
   );

   fac_combine u_combine (
      .clock  (clock),
      .enable (enable),
      .prod   (prod),
      .y_ff   (y_cmd)
   );

   fac_limit_code u_limit (
      .clock       (clock),
      .enable      (enable),
      .y           (y_cmd),
      .accel_upper (cfg_ff.accel_upper),
      .accel_lower (cfg_ff.accel_lower),
      .code_ff     (code),
      .limited_ff  (limited)
   );

   // Result channel
   assign rsp_tvalid = valid_ff[4];
   assign rsp_tdata  = {7'd0, code};
   assign rsp_tuser  = limited;

endmodule
